>>> hdl/bstt_pkg.sv
package bstt_pkg;

    // Defaults for the top level parameters
    localparam int MAX_SPAN_DEF  = 64;
    localparam int MAX_DIM_DEF   = 4096;
    localparam int FRAC_BITS_DEF = 16;

    // Width of the doubled-centre sum (coef * (2p+1) + 2*offset)
    localparam int SUM_W  = 52;
    localparam int PROD_W = 50;
    localparam int SIZE_W = 13;
    localparam int CNT_W  = 7;

    // Register indices
    localparam logic [2:0] REG_COEF_A = 3'd0;
    localparam logic [2:0] REG_COEF_B = 3'd1;
    localparam logic [2:0] REG_COEF_C = 3'd2;
    localparam logic [2:0] REG_COEF_D = 3'd3;
    localparam logic [2:0] REG_COEF_E = 3'd4;
    localparam logic [2:0] REG_COEF_F = 3'd5;
    localparam logic [2:0] REG_DIMS   = 3'd6;
    localparam logic [2:0] REG_MODE   = 3'd7;

    // Tile modes
    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;
    localparam logic [1:0] MODE_RAW    = 2'd3;

    typedef struct packed {
        logic signed [15:0] span_x;
        logic signed [15:0] span_y;
        logic [6:0]         span_count;
    } span_req_t;

    typedef struct packed {
        logic [11:0] texel_col;
        logic [11:0] texel_row;
        logic        in_range;
        logic        last;
    } texel_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_DIV_INIT,
        S_DIV,
        S_EMIT
    } bstt_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic div_start;
        logic div_step;
        logic emit;
    } bstt_cmd_t;

    typedef struct packed {
        logic empty;
        logic need_div;
        logic div_done;
        logic last_pixel;
        logic out_free;
    } bstt_stat_t;

endpackage

>>> hdl/bstt_ctrl.sv
module bstt_ctrl
    import bstt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bstt_stat_t stat,
    output bstt_cmd_t  cmd
);

    bstt_state_t state_reg;
    bstt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (stat.empty)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.need_div)
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DIV_INIT:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.last_pixel)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.need_div)
                    begin
                        state_next = S_DIV_INIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MUL:      cmd.mul = 1'b1;
            S_SUM:      cmd.sum = 1'b1;
            S_DIV_INIT: cmd.div_start = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_EMIT:     cmd.emit = stat.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> hdl/bstt_dp.sv
module bstt_dp
    import bstt_pkg::*;
#(
    parameter int MAX_SPAN  = MAX_SPAN_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  span_req_t   in_data,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        out_ready,
    output logic        out_valid,
    output texel_res_t  out_data,
    input  bstt_cmd_t   cmd,
    output bstt_stat_t  stat
);

    localparam int T_W    = SUM_W - FRAC_BITS - 1;
    localparam int STEP_W = $clog2(T_W);

    typedef struct packed {
        logic        ok;
        logic [11:0] val;
    } axis_t;

    // Fold one texel coordinate into the bitmap. rem/q/neg come from |t| / size.
    function automatic axis_t fold_axis(input logic signed [T_W-1:0] t,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [1:0] mode,
                                        input logic [SIZE_W-1:0] rem,
                                        input logic q,
                                        input logic neg);
        axis_t             res;
        logic [SIZE_W-1:0] r;
        logic              par;
        logic signed [T_W-1:0] size_s;
        res    = '0;
        size_s = T_W'($signed({1'b0, size}));
        r      = rem;
        par    = q;
        if (neg && (rem != '0))
        begin
            r   = size - rem;
            par = ~q;
        end
        case (mode)
            MODE_CLAMP:
            begin
                res.ok = 1'b1;
                if (t < 0)
                    res.val = '0;
                else if (t >= size_s)
                    res.val = 12'(size - 13'd1);
                else
                    res.val = t[11:0];
            end
            MODE_REPEAT:
            begin
                res.ok  = 1'b1;
                res.val = r[11:0];
            end
            MODE_MIRROR:
            begin
                res.ok  = 1'b1;
                res.val = par ? 12'(size - 13'd1 - r) : r[11:0];
            end
            default:
            begin
                res.ok  = (t >= 0) && (t < size_s);
                res.val = t[11:0];
            end
        endcase
        return res;
    endfunction

    // Configuration
    logic signed [31:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic signed [31:0] coef_d_reg, coef_e_reg, coef_f_reg;
    logic [23:0]        dims_reg;
    logic [1:0]         mode_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg   <= 32'sd65536;
            coef_b_reg   <= '0;
            coef_c_reg   <= '0;
            coef_d_reg   <= '0;
            coef_e_reg   <= 32'sd65536;
            coef_f_reg   <= '0;
            dims_reg     <= '0;
            mode_cfg_reg <= MODE_CLAMP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_A: coef_a_reg   <= cfg_data;
                REG_COEF_B: coef_b_reg   <= cfg_data;
                REG_COEF_C: coef_c_reg   <= cfg_data;
                REG_COEF_D: coef_d_reg   <= cfg_data;
                REG_COEF_E: coef_e_reg   <= cfg_data;
                REG_COEF_F: coef_f_reg   <= cfg_data;
                REG_DIMS:   dims_reg     <= cfg_data[23:0];
                REG_MODE:   mode_cfg_reg <= cfg_data[1:0];
                default:    dims_reg     <= dims_reg;
            endcase
        end
    end

    // Span setup
    logic signed [17:0]  x2_reg;
    logic signed [16:0]  y2_reg;
    logic [CNT_W-1:0]    count_reg, idx_reg;
    logic [SIZE_W-1:0]   w_reg, h_reg;
    logic [1:0]          mode_reg;
    logic [SIZE_W-1:0]   w_full, h_full;
    logic [CNT_W-1:0]    count_sat;

    assign w_full    = {1'b0, dims_reg[11:0]} + 13'd1;
    assign h_full    = {1'b0, dims_reg[23:12]} + 13'd1;
    assign count_sat = (in_data.span_count > CNT_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN)
                                                              : in_data.span_count;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x2_reg    <= {in_data.span_x[15], in_data.span_x, 1'b1};
            y2_reg    <= {in_data.span_y, 1'b1};
            count_reg <= count_sat;
            w_reg     <= (w_full > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : w_full;
            h_reg     <= (h_full > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : h_full;
            mode_reg  <= mode_cfg_reg;
        end
    end

    // Products, then initial sums, then one step of 2a / 2d per pixel
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pd_reg, pe_reg;
    logic signed [SUM_W-1:0]  su_reg, sv_reg;
    logic signed [32:0]       c2, f2, a2, d2;

    assign c2 = {coef_c_reg, 1'b0};
    assign f2 = {coef_f_reg, 1'b0};
    assign a2 = {coef_a_reg, 1'b0};
    assign d2 = {coef_d_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            pa_reg <= coef_a_reg * x2_reg;
            pd_reg <= coef_d_reg * x2_reg;
            pb_reg <= coef_b_reg * y2_reg;
            pe_reg <= coef_e_reg * y2_reg;
        end
        if (cmd.sum)
        begin
            su_reg <= SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(c2);
            sv_reg <= SUM_W'(pd_reg) + SUM_W'(pe_reg) + SUM_W'(f2);
        end
        else if (cmd.emit)
        begin
            su_reg <= su_reg + SUM_W'(a2);
            sv_reg <= sv_reg + SUM_W'(d2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.load)
            idx_reg <= '0;
        else if (cmd.emit)
            idx_reg <= idx_reg + CNT_W'(1);
    end

    // Integer texel coordinates: floor of sum / 2^(FRAC_BITS+1)
    logic signed [T_W-1:0] tu, tv;
    assign tu = T_W'(su_reg >>> (FRAC_BITS + 1));
    assign tv = T_W'(sv_reg >>> (FRAC_BITS + 1));

    // Restoring dividers, one quotient bit a cycle, for |t| mod size
    logic [T_W-1:0]    mu_reg, mv_reg;
    logic [SIZE_W-1:0] ru_reg, rv_reg;
    logic              qu_reg, qv_reg, nu_reg, nv_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SIZE_W:0]   trial_u, trial_v;

    assign trial_u = {ru_reg, mu_reg[T_W-1]};
    assign trial_v = {rv_reg, mv_reg[T_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            mu_reg   <= tu[T_W-1] ? T_W'(-tu) : T_W'(tu);
            mv_reg   <= tv[T_W-1] ? T_W'(-tv) : T_W'(tv);
            nu_reg   <= tu[T_W-1];
            nv_reg   <= tv[T_W-1];
            ru_reg   <= '0;
            rv_reg   <= '0;
            qu_reg   <= 1'b0;
            qv_reg   <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mu_reg   <= {mu_reg[T_W-2:0], 1'b0};
            mv_reg   <= {mv_reg[T_W-2:0], 1'b0};
            step_reg <= step_reg + STEP_W'(1);
            if (trial_u >= {1'b0, w_reg})
            begin
                ru_reg <= SIZE_W'(trial_u - {1'b0, w_reg});
                qu_reg <= 1'b1;
            end
            else
            begin
                ru_reg <= trial_u[SIZE_W-1:0];
                qu_reg <= 1'b0;
            end
            if (trial_v >= {1'b0, h_reg})
            begin
                rv_reg <= SIZE_W'(trial_v - {1'b0, h_reg});
                qv_reg <= 1'b1;
            end
            else
            begin
                rv_reg <= trial_v[SIZE_W-1:0];
                qv_reg <= 1'b0;
            end
        end
    end

    // Result and output register
    axis_t      col_res, row_res;
    logic       ok;
    texel_res_t res;
    logic       out_valid_reg;
    texel_res_t out_data_reg;

    assign col_res = fold_axis(tu, w_reg, mode_reg, ru_reg, qu_reg, nu_reg);
    assign row_res = fold_axis(tv, h_reg, mode_reg, rv_reg, qv_reg, nv_reg);
    assign ok      = col_res.ok && row_res.ok;

    always_comb
    begin
        res.texel_col = ok ? col_res.val : '0;
        res.texel_row = ok ? row_res.val : '0;
        res.in_range  = ok;
        res.last      = !ok || ((idx_reg + CNT_W'(1)) == count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.empty      = (count_reg == '0);
    assign stat.need_div   = (mode_reg == MODE_REPEAT) || (mode_reg == MODE_MIRROR);
    assign stat.div_done   = (step_reg == STEP_W'(T_W - 1));
    assign stat.last_pixel = res.last;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

>>> hdl/bitmap_span_texel_tiling.sv
// Span texel addressing for an affine-mapped bitmap.
// in channel (in_valid/in_ready/in_data): one span request per transfer.
// out channel (out_valid/out_ready/out_data): one texel per pixel, last
// set on the final one; a span stops early on an out-of-range texel.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while the block is idle.
// In clamp and raw modes a request goes through the multiply and sum
// steps, then one texel a cycle while the receiver keeps up. In repeat
// and mirror modes each texel goes through the shared-step restoring
// dividers, one quotient bit a cycle, over a 51 - FRAC_BITS bit |t|
// (35 bits at Q16.16). The next request is taken only once the final
// texel of the span has gone to the result register.
// The result register frees the datapath: a new request is taken while
// the final texel still waits. When the receiver stalls, the next texel
// is held in the datapath until the result register frees.
// Reset restores the identity matrix, a 1x1 bitmap and clamp mode.
module bitmap_span_texel_tiling
    import bstt_pkg::*;
#(
    parameter int MAX_SPAN  = MAX_SPAN_DEF,
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  span_req_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output texel_res_t  out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    bstt_cmd_t  cmd;
    bstt_stat_t stat;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    bstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bstt_dp #(
        .MAX_SPAN  (MAX_SPAN),
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
